>>> rtl/core/bsdd_pkg.sv
// Package with the default sizes shared by the biphase symbol decoder.
package bsdd_pkg;

  // Symbols counted in one polarity decision window.
  localparam int unsigned DEFAULT_WINDOW_LENGTH = 128;

  // Width of one signed fixed-point symbol word.
  localparam int unsigned DEFAULT_SAMPLE_WIDTH = 16;

endpackage

>>> rtl/core/biphase_symbol_differential_decoder.sv
// Biphase symbol differential decoder: half difference, polarity tracking, data bit out.
//
// The symbol channel (symbol_valid, symbol_stall, symbol_real) takes one word per cycle
// while symbol_stall is low. Each word is the real part of a demodulated PSK symbol in
// signed fixed point. The bit channel (bit_valid, bit_stall, biphase_level, decoded_bit,
// polarity_in_use) carries at most one word per symbol. A word is sent only for symbols
// whose phase parity matches the current clock polarity.
// An accepted symbol's bit word appears in the next cycle. The block accepts one symbol
// every cycle while symbol_stall is low. All per-symbol work is one subtract, one absolute
// value, one accumulate and one compare, sitting between the state and output registers.
// When the receiver stalls, the output register holds its word. symbol_stall is raised only
// while a held word is waiting, so a symbol still enters in the same cycle that the pending
// word is taken.
// A synchronous reset clears the previous symbol, the phase counter, the polarity, both
// magnitude sums, the last sign and the output valid flag. There is no clearing pass, and
// the block is ready in the first cycle after reset.
module biphase_symbol_differential_decoder
  import bsdd_pkg::*;
#(
  parameter int unsigned WINDOW_LENGTH = DEFAULT_WINDOW_LENGTH,
  parameter int unsigned SAMPLE_WIDTH  = DEFAULT_SAMPLE_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           symbol_valid,
  output logic                           symbol_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] symbol_real,
  output logic                           bit_valid,
  input  logic                           bit_stall,
  output logic signed [SAMPLE_WIDTH-1:0] biphase_level,
  output logic                           decoded_bit,
  output logic                           polarity_in_use
);

  // The phase counter runs 0 .. WINDOW_LENGTH-1.
  localparam int unsigned PHASE_W = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
  // Each parity sees at most ceil(WINDOW_LENGTH/2) magnitudes of up to 2^(SAMPLE_WIDTH-1).
  // So this width never wraps.
  localparam int unsigned SUM_W = SAMPLE_WIDTH - 1 + PHASE_W;
  localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(WINDOW_LENGTH - 1);

  // State registers.
  logic signed [SAMPLE_WIDTH-1:0] previous_symbol;
  logic [PHASE_W-1:0]             phase_counter;
  logic                           clock_polarity;
  logic [SUM_W-1:0]               even_magnitude_sum;
  logic [SUM_W-1:0]               odd_magnitude_sum;
  logic                           previous_sign_bit;

  // Combinational datapath.
  logic                           accept;
  logic signed [SAMPLE_WIDTH:0]   difference;
  logic signed [SAMPLE_WIDTH-1:0] level;
  logic [SAMPLE_WIDTH-1:0]        magnitude;
  logic                           parity;
  logic                           emit;
  logic                           sign_bit;
  logic                           window_end;
  logic [SUM_W-1:0]               even_magnitude_sum_next;
  logic [SUM_W-1:0]               odd_magnitude_sum_next;
  logic                           clock_polarity_next;

  // The output register is held only while its word waits on a stalled receiver.
  assign symbol_stall = bit_valid && bit_stall;
  assign accept       = symbol_valid && !symbol_stall;

  // The difference is formed one bit wider. Dropping its lowest bit is the floor of half
  // the difference, and that result always fits back into SAMPLE_WIDTH bits.
  assign difference = {symbol_real[SAMPLE_WIDTH-1], symbol_real}
                    - {previous_symbol[SAMPLE_WIDTH-1], previous_symbol};
  assign level      = difference[SAMPLE_WIDTH:1];

  // The most negative level has magnitude 2^(SAMPLE_WIDTH-1), which still fits unsigned.
  assign magnitude  = level[SAMPLE_WIDTH-1] ? (~level + 1'b1) : level;

  assign parity     = phase_counter[0];
  assign emit       = (parity == clock_polarity);
  assign sign_bit   = ~level[SAMPLE_WIDTH-1];
  assign window_end = (phase_counter == PHASE_LAST);

  // The magnitude of this symbol counts toward the decision taken at the end of this window.
  always_comb begin
    even_magnitude_sum_next = even_magnitude_sum;
    odd_magnitude_sum_next  = odd_magnitude_sum;
    if (parity) begin
      odd_magnitude_sum_next = odd_magnitude_sum + SUM_W'(magnitude);
    end else begin
      even_magnitude_sum_next = even_magnitude_sum + SUM_W'(magnitude);
    end
    // The larger sum picks the polarity. A tie keeps the current polarity.
    clock_polarity_next = clock_polarity;
    if (even_magnitude_sum_next > odd_magnitude_sum_next) begin
      clock_polarity_next = 1'b0;
    end else if (odd_magnitude_sum_next > even_magnitude_sum_next) begin
      clock_polarity_next = 1'b1;
    end
  end

  // State update. Non-emitting symbols still advance the history, the sums and the counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_symbol    <= '0;
      phase_counter      <= '0;
      clock_polarity     <= 1'b0;
      even_magnitude_sum <= '0;
      odd_magnitude_sum  <= '0;
      previous_sign_bit  <= 1'b0;
    end else if (accept) begin
      previous_symbol <= symbol_real;
      if (emit) begin
        previous_sign_bit <= sign_bit;
      end
      if (window_end) begin
        phase_counter      <= '0;
        clock_polarity     <= clock_polarity_next;
        even_magnitude_sum <= '0;
        odd_magnitude_sum  <= '0;
      end else begin
        phase_counter      <= phase_counter + 1'b1;
        even_magnitude_sum <= even_magnitude_sum_next;
        odd_magnitude_sum  <= odd_magnitude_sum_next;
      end
    end
  end

  // Output register control. An accepted symbol either fills the register or leaves it
  // empty. Acceptance implies that any previous word is being taken in this cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_valid <= 1'b0;
    end else if (accept) begin
      bit_valid <= emit;
    end else if (!bit_stall) begin
      bit_valid <= 1'b0;
    end
  end

  // Output payload. The polarity reported is the one in force before any window update.
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      biphase_level   <= level;
      decoded_bit     <= sign_bit ^ previous_sign_bit;
      polarity_in_use <= clock_polarity;
    end
  end

  // An emitted word carries the polarity that selected it.
  assert property (@(posedge clk) disable iff (rst)
    (accept && emit) |=> (bit_valid && polarity_in_use == $past(clock_polarity)))
    else $error("emitted word lost or carries the wrong polarity");

  // A symbol that emits nothing leaves the output register empty.
  assert property (@(posedge clk) disable iff (rst)
    (accept && !emit) |=> !bit_valid)
    else $error("output valid after a non-emitting symbol");

  // The polarity changes only when a window closes.
  assert property (@(posedge clk) disable iff (rst)
    !(accept && window_end) |=> $stable(clock_polarity))
    else $error("polarity changed inside a window");

  // Both sums and the phase counter start the new window cleared.
  assert property (@(posedge clk) disable iff (rst)
    (accept && window_end) |=> (even_magnitude_sum == '0 && odd_magnitude_sum == '0
                                && phase_counter == '0))
    else $error("window state not cleared at window end");

endmodule

>>> bench/tb.sv
// Self-checking testbench for the biphase symbol differential decoder.
`timescale 1ns / 1ps

module tb;
  import bsdd_pkg::*;

  localparam int SW = DEFAULT_SAMPLE_WIDTH;
  localparam int WIN = DEFAULT_WINDOW_LENGTH;
  localparam int PW = $clog2(WIN);
  localparam int SUM_W = 22;
  // Cycles without any accepted word before the run is declared hung. This lies well
  // beyond the longest sender gap and receiver stall that the bench draws, so no correct
  // run reaches it.
  localparam int HANG_LIMIT = 1000;
  localparam int MAX_SHOWN = 10;

  // One expected word on the bit channel.
  typedef struct packed {
    logic signed [SW-1:0] level;
    logic                 data;
    logic                 polarity;
  } bit_word_t;

  // The send queue holds symbols and a few markers that steer the driver.
  typedef enum logic [1:0] {
    ITEM_SYMBOL,
    ITEM_DRAIN,
    ITEM_CALM,
    ITEM_BUSY
  } item_kind_t;

  typedef struct {
    item_kind_t           kind;
    logic signed [SW-1:0] value;
  } pending_item_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 symbol_valid = 1'b0;
  logic                 symbol_stall;
  logic signed [SW-1:0] symbol_real = '0;
  logic                 bit_valid;
  logic                 bit_stall = 1'b0;
  logic signed [SW-1:0] biphase_level;
  logic                 decoded_bit;
  logic                 polarity_in_use;

  biphase_symbol_differential_decoder i_dut (
    .clk             (clk),
    .rst             (rst),
    .symbol_valid    (symbol_valid),
    .symbol_stall    (symbol_stall),
    .symbol_real     (symbol_real),
    .bit_valid       (bit_valid),
    .bit_stall       (bit_stall),
    .biphase_level   (biphase_level),
    .decoded_bit     (decoded_bit),
    .polarity_in_use (polarity_in_use)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the decoder state, advanced once per accepted symbol.
  logic signed [SW-1:0] prev_symbol = '0;
  logic [PW-1:0]        phase_count = '0;
  logic                 polarity = 1'b0;
  logic [SUM_W-1:0]     even_sum = '0;
  logic [SUM_W-1:0]     odd_sum = '0;
  logic                 last_sign = 1'b0;

  bit_word_t     bit_words_due[$];
  pending_item_t symbols_to_send[$];

  int   fault_count = 0;
  int   idle_cycles = 0;
  int   gap_left = 0;
  int   stall_left = 0;
  int   pick;
  int   stall_pick;
  logic calm = 1'b0;
  logic sym_taken = 1'b0;

  // Advances the shadow state by one symbol and queues the word it should produce,
  // if any. The halving is an arithmetic shift, so the level is just the upper bits
  // of the widened difference, and it always fits the sample width.
  function automatic void decode_symbol(input logic signed [SW-1:0] sym);
    logic signed [SW:0] diff;
    logic signed [SW-1:0] level;
    logic [SW:0] mag;
    logic sign_now;
    bit_word_t word;
    diff = sym - prev_symbol;
    level = diff[SW:1];
    // Two's complement negate of the sign-extended level; the most negative
    // level gives exactly 2^(SW-1).
    mag = level[SW-1] ? -{level[SW-1], level} : {1'b0, level};
    sign_now = ~level[SW-1];
    if (phase_count[0] == polarity) begin
      word.level = level;
      word.data = sign_now ^ last_sign;
      word.polarity = polarity;
      bit_words_due.insert(bit_words_due.size(), word);
      last_sign = sign_now;
    end
    if (phase_count[0]) begin
      odd_sum = odd_sum + mag;
    end else begin
      even_sum = even_sum + mag;
    end
    prev_symbol = sym;
    // The window closes after its last symbol has been counted; a tie keeps the
    // polarity that was in force.
    if (phase_count == WIN - 1) begin
      if (even_sum > odd_sum) begin
        polarity = 1'b0;
      end else if (odd_sum > even_sum) begin
        polarity = 1'b1;
      end
      even_sum = '0;
      odd_sum = '0;
      phase_count = '0;
    end else begin
      phase_count = phase_count + 1'b1;
    end
  endfunction

  // Sampling side: check outgoing words first, then predict from the symbol taken at
  // this edge, so the oldest expectation is always the one compared.
  always @(posedge clk) begin
    if (rst) begin
      sym_taken <= 1'b0;
      idle_cycles <= 0;
    end else begin
      sym_taken <= symbol_valid && !symbol_stall;
      if (bit_valid && !bit_stall) begin
        if (bit_words_due.size() == 0) begin
          fault_count++;
          if (fault_count <= MAX_SHOWN) begin
            $display("tb: unexpected word level=%0d data=%0b polarity=%0b",
                     biphase_level, decoded_bit, polarity_in_use);
          end
        end else begin
          bit_word_t want;
          want = bit_words_due.pop_front();
          if (biphase_level !== want.level || decoded_bit !== want.data ||
              polarity_in_use !== want.polarity) begin
            fault_count++;
            if (fault_count <= MAX_SHOWN) begin
              $display("tb: mismatch expected level=%0d data=%0b polarity=%0b,",
                       want.level, want.data, want.polarity,
                       " got level=%0d data=%0b polarity=%0b",
                       biphase_level, decoded_bit, polarity_in_use);
            end
          end
        end
      end
      if (symbol_valid && !symbol_stall) begin
        decode_symbol(symbol_real);
      end
      // Watchdog: any accepted word on either channel counts as progress.
      if ((symbol_valid && !symbol_stall) || (bit_valid && !bit_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= HANG_LIMIT) begin
        $display("tb: errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Driver: moves to the next queue entry once the current symbol has been taken.
  // After each symbol it picks a gap: none while calm, else mostly none, sometimes short, rarely long.
  always @(negedge clk) begin
    if (rst) begin
      symbol_valid <= 1'b0;
      gap_left <= 0;
    end else if (!symbol_valid || sym_taken) begin
      if (gap_left > 0) begin
        symbol_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (symbols_to_send.size() == 0) begin
        symbol_valid <= 1'b0;
      end else if (symbols_to_send[0].kind == ITEM_DRAIN) begin
        // Hold off until every word already owed by the decoder has come out.
        symbol_valid <= 1'b0;
        if (bit_words_due.size() == 0) begin
          void'(symbols_to_send.pop_front());
        end
      end else if (symbols_to_send[0].kind != ITEM_SYMBOL) begin
        symbol_valid <= 1'b0;
        calm <= (symbols_to_send[0].kind == ITEM_CALM);
        void'(symbols_to_send.pop_front());
      end else begin
        symbol_real <= symbols_to_send[0].value;
        symbol_valid <= 1'b1;
        void'(symbols_to_send.pop_front());
        pick = $urandom_range(0, 99);
        if (calm || pick < 70) begin
          gap_left <= 0;
        end else if (pick < 94) begin
          gap_left <= $urandom_range(1, 3);
        end else begin
          gap_left <= $urandom_range(10, 40);
        end
      end
    end
  end

  // Receiver stall: outside calm stretches, runs of open cycles alternate with short and occasional long stalls.
  always @(negedge clk) begin
    if (rst || calm) begin
      bit_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 60) begin
        bit_stall <= 1'b0;
        stall_left <= $urandom_range(1, 8);
      end else if (stall_pick < 93) begin
        bit_stall <= 1'b1;
        stall_left <= $urandom_range(0, 2);
      end else begin
        bit_stall <= 1'b1;
        stall_left <= $urandom_range(10, 40);
      end
    end
  end

  int symbol_total = 0;

  task automatic push_symbol(input int v);
    pending_item_t it;
    if (v > 32767) begin
      v = 32767;
    end else if (v < -32768) begin
      v = -32768;
    end
    it.kind = ITEM_SYMBOL;
    it.value = v[SW-1:0];
    symbols_to_send.insert(symbols_to_send.size(), it);
    symbol_total++;
  endtask

  task automatic push_marker(input item_kind_t kind);
    pending_item_t it;
    it.kind = kind;
    it.value = '0;
    symbols_to_send.insert(symbols_to_send.size(), it);
  endtask

  initial begin
    int seg;
    int len;
    int amp;
    int noise;
    int level_sign;
    int v;

    // Directed opening: full-scale swings both ways, the most negative level, a zero
    // level with a negative previous sign, and the rounding of odd differences.
    push_symbol(0);
    push_symbol(32767);
    push_symbol(-32768);
    push_symbol(32767);
    push_symbol(0);
    push_symbol(-1);
    push_symbol(0);
    push_symbol(1);
    push_symbol(0);
    push_symbol(-32768);
    push_symbol(-32768);
    push_symbol(32767);
    push_symbol(32767);
    push_symbol(-3);
    push_symbol(2);
    push_symbol(-32767);
    push_symbol(32766);
    push_symbol(0);
    push_marker(ITEM_DRAIN);

    // Random part. Most of it is biphase-coded data, where each bit is a pair of
    // opposite symbols, so one phase parity carries the large levels and the window
    // logic has a real polarity to find. Single extra symbols slip the pairing and
    // force the polarity to move; constant runs give tied windows.
    while (symbol_total < 1250) begin
      seg = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) begin
        push_marker(ITEM_CALM);
      end
      if (seg < 50) begin
        len = $urandom_range(8, 64);
        amp = $urandom_range(2000, 32767);
        noise = $urandom_range(0, 3000);
        repeat (len) begin
          level_sign = $urandom_range(0, 1) ? amp : -amp;
          push_symbol(level_sign + $urandom_range(0, 2 * noise) - noise);
          push_symbol(-level_sign + $urandom_range(0, 2 * noise) - noise);
        end
      end else if (seg < 60) begin
        push_symbol($urandom_range(0, 65535) - 32768);
      end else if (seg < 75) begin
        repeat ($urandom_range(1, 40)) begin
          push_symbol($urandom_range(0, 65535) - 32768);
        end
      end else if (seg < 81) begin
        v = $urandom_range(0, 65535) - 32768;
        repeat ($urandom_range(130, 260)) begin
          push_symbol(v);
        end
      end else if (seg < 92) begin
        repeat ($urandom_range(4, 30)) begin
          push_symbol($urandom_range(0, 8) - 4);
        end
      end else begin
        push_marker(ITEM_DRAIN);
      end
      push_marker(ITEM_BUSY);
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    do begin
      @(posedge clk);
    end while (symbols_to_send.size() != 0 || symbol_valid || bit_words_due.size() != 0);
    // Keep the clock running to catch any stray word.
    repeat (20) @(posedge clk);

    if (fault_count == 0 && bit_words_due.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

>>> biphase_symbol_differential_decoder.f
rtl/core/bsdd_pkg.sv
rtl/core/biphase_symbol_differential_decoder.sv
bench/tb.sv
